FILE: sv/ikarm_pkg.sv
// ----------------------------------------------------------------------------
// ikarm_pkg
// Shared types, constants and helper functions of the arm inverse kinematics
// block.
// ----------------------------------------------------------------------------
package ikarm_pkg;

  localparam int QF                     = 20;
  localparam int ANGLE_FRAC_BITS        = 4;
  localparam int OUT_SHIFT              = QF - ANGLE_FRAC_BITS;
  localparam int CORDIC_ITERATIONS_DEF  = 16;
  localparam int CORDIC_IN_W            = 32;
  localparam int CORDIC_W               = CORDIC_IN_W + QF + 2;
  localparam int ANGLE_W                = 34;
  localparam int ROUND_W                = ANGLE_W - OUT_SHIFT;
  localparam int QUEUE_DEPTH            = 4;

  localparam int BASE_LO_DEG     = 0;
  localparam int BASE_HI_DEG     = 270;
  localparam int SHOULDER_LO_DEG = 75;
  localparam int SHOULDER_HI_DEG = 170;
  localparam int ELBOW_LO_DEG    = 50;
  localparam int ELBOW_HI_DEG    = 160;

  localparam int OUT_MAX = 8191;
  localparam int OUT_MIN = -8192;

  typedef enum logic [2:0] {
    REG_Z_BRACKET_OFFSET      = 3'd0,
    REG_RADIAL_OFFSET         = 3'd1,
    REG_SHOULDER_HEIGHT       = 3'd2,
    REG_UPPER_LINK_LENGTH     = 3'd3,
    REG_FORE_LINK_LENGTH      = 3'd4,
    REG_SHOULDER_SERVO_OFFSET = 3'd5,
    REG_ELBOW_SERVO_OFFSET    = 3'd6,
    REG_BASE_SERVO_OFFSET     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [12:0] z_bracket_offset;
    logic [12:0]        radial_offset;
    logic [12:0]        shoulder_height;
    logic [12:0]        upper_link_length;
    logic [12:0]        fore_link_length;
    logic [12:0]        shoulder_servo_offset;
    logic [12:0]        elbow_servo_offset;
    logic [12:0]        base_servo_offset;
  } cfg_t;

  // One classified target as it sits in the queue.
  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [16:0] hx;
    logic               base_ok;
    logic               both_neg;
  } item_t;

  // Arctangent of 2^-i in Q20 degrees.
  function automatic logic signed [ANGLE_W-1:0] atan_q20(input int i);
    logic signed [ANGLE_W-1:0] v;
    unique case (i)
      0:  v = ANGLE_W'(47185920);
      1:  v = ANGLE_W'(27855475);
      2:  v = ANGLE_W'(14718068);
      3:  v = ANGLE_W'(7471121);
      4:  v = ANGLE_W'(3750058);
      5:  v = ANGLE_W'(1876857);
      6:  v = ANGLE_W'(938658);
      7:  v = ANGLE_W'(469357);
      8:  v = ANGLE_W'(234682);
      9:  v = ANGLE_W'(117342);
      10: v = ANGLE_W'(58671);
      11: v = ANGLE_W'(29335);
      12: v = ANGLE_W'(14668);
      13: v = ANGLE_W'(7334);
      14: v = ANGLE_W'(3667);
      15: v = ANGLE_W'(1833);
      16: v = ANGLE_W'(917);
      17: v = ANGLE_W'(458);
      18: v = ANGLE_W'(229);
      19: v = ANGLE_W'(115);
      20: v = ANGLE_W'(57);
      21: v = ANGLE_W'(29);
      22: v = ANGLE_W'(14);
      23: v = ANGLE_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Whole degrees to Q20 degrees.
  function automatic logic signed [ANGLE_W-1:0] deg_q(input int d);
    return ANGLE_W'(d) <<< QF;
  endfunction

  // Servo offset in output units to Q20 degrees.
  function automatic logic signed [ANGLE_W-1:0] off_q(input logic [12:0] r);
    return $signed(ANGLE_W'(r)) <<< OUT_SHIFT;
  endfunction

  // Q20 degrees to output units, nearest with halves up.
  function automatic logic signed [ROUND_W-1:0] round_out(
    input logic signed [ANGLE_W-1:0] q
  );
    logic signed [ANGLE_W-1:0] s;
    s = q + (ANGLE_W'(1) <<< (OUT_SHIFT - 1));
    return s[ANGLE_W-1:OUT_SHIFT];
  endfunction

  // Whole degrees to output units.
  function automatic logic signed [ROUND_W-1:0] lim(input int d);
    return ROUND_W'(d) <<< ANGLE_FRAC_BITS;
  endfunction

  function automatic logic signed [13:0] sat_out(input logic signed [ROUND_W-1:0] v);
    logic signed [13:0] o;
    if (v > ROUND_W'(OUT_MAX)) begin
      o = 14'(OUT_MAX);
    end else if (v < ROUND_W'(OUT_MIN)) begin
      o = 14'(OUT_MIN);
    end else begin
      o = v[13:0];
    end
    return o;
  endfunction

endpackage

FILE: sv/ikarm_front.sv
// ----------------------------------------------------------------------------
// ikarm_front
// Input stage: takes a target, adds the bracket offset, forms the height
// below the shoulder and classifies the base quadrant, then feeds the queue.
// ----------------------------------------------------------------------------
module ikarm_front (
  input  logic               clk,
  input  logic               rst,
  input  ikarm_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [13:0] target_x,
  input  logic signed [13:0] target_y,
  input  logic signed [13:0] target_z,
  input  logic               q_full,
  output logic               q_push,
  output ikarm_pkg::item_t   q_item
);
  import ikarm_pkg::*;

  logic               f_valid;
  logic               accept;
  logic signed [14:0] zz;
  item_t              cls;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid && !q_full;

  always_comb begin
    zz           = 15'(target_z) + 15'(cfg.z_bracket_offset);
    cls.x        = target_x;
    cls.y        = target_y;
    cls.hx       = 17'($signed({1'b0, cfg.shoulder_height})) - 17'(zz);
    cls.base_ok  = (target_x != '0) || (target_y != '0);
    cls.both_neg = target_x[13] && target_y[13];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_item <= cls;
    end
  end

endmodule

FILE: sv/ikarm_fifo.sv
// ----------------------------------------------------------------------------
// ikarm_fifo
// Short queue of classified targets between the front and the back.
// ----------------------------------------------------------------------------
module ikarm_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ikarm_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output ikarm_pkg::item_t head,
  output logic             empty
);
  import ikarm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/ikarm_isqrt.sv
// ----------------------------------------------------------------------------
// ikarm_isqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ikarm_isqrt #(
  parameter int W = 30
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   radicand,
  output logic [W/2-1:0] root
);
  localparam int K = W / 2;

  logic [W-1:0] rem [K];
  logic [K-1:0] q   [K];

  for (genvar k = 0; k < K; k++) begin : g_stage
    localparam int B = K - 1 - k;
    logic [W-1:0] r_in;
    logic [K-1:0] q_in;
    logic [W:0]   trial;

    if (k == 0) begin : g_first
      assign r_in = radicand;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign q_in = q[k-1];
    end

    // (q + 2^B)^2 - q^2
    assign trial = ((W+1)'(q_in) << (B + 1)) + ((W+1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ((W+1)'(r_in) >= trial) begin
          rem[k] <= r_in - trial[W-1:0];
          q[k]   <= q_in | (K'(1) << B);
        end else begin
          rem[k] <= r_in;
          q[k]   <= q_in;
        end
      end
    end
  end

  assign root = q[K-1];

endmodule

FILE: sv/ikarm_cordic.sv
// ----------------------------------------------------------------------------
// ikarm_cordic
// Pipelined vectoring CORDIC: angle of (x, y) in Q20 degrees.
// ----------------------------------------------------------------------------
module ikarm_cordic #(
  parameter int ITERATIONS = ikarm_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [ikarm_pkg::CORDIC_IN_W-1:0] y_in,
  input  logic signed [ikarm_pkg::CORDIC_IN_W-1:0] x_in,
  output logic signed [ikarm_pkg::ANGLE_W-1:0]     z_out
);
  import ikarm_pkg::*;

  logic signed [CORDIC_W-1:0] xs [ITERATIONS+1];
  logic signed [CORDIC_W-1:0] ys [ITERATIONS+1];
  logic signed [ANGLE_W-1:0]  zs [ITERATIONS+1];

  logic signed [CORDIC_W-1:0] xsc;
  logic signed [CORDIC_W-1:0] ysc;

  assign xsc = {{2{x_in[CORDIC_IN_W-1]}}, x_in, {QF{1'b0}}};
  assign ysc = {{2{y_in[CORDIC_IN_W-1]}}, y_in, {QF{1'b0}}};

  // Pre-rotate the left half plane by a quarter turn.
  always_ff @(posedge clk) begin
    if (en) begin
      if (xsc[CORDIC_W-1] && !ysc[CORDIC_W-1]) begin
        xs[0] <= ysc;
        ys[0] <= -xsc;
        zs[0] <= deg_q(90);
      end else if (xsc[CORDIC_W-1]) begin
        xs[0] <= -ysc;
        ys[0] <= xsc;
        zs[0] <= -deg_q(90);
      end else begin
        xs[0] <= xsc;
        ys[0] <= ysc;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][CORDIC_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_q20(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_q20(i);
        end
      end
    end
  end

  assign z_out = zs[ITERATIONS];

endmodule

FILE: sv/ikarm_back.sv
// ----------------------------------------------------------------------------
// ikarm_back
// Solver pipeline: reach, triangle test, four CORDIC angles, servo mapping,
// limit checks and the output register. Advances as one unit.
// ----------------------------------------------------------------------------
module ikarm_back #(
  parameter int CORDIC_ITERATIONS = ikarm_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ikarm_pkg::cfg_t    cfg,
  input  logic               q_empty,
  input  ikarm_pkg::item_t   q_head,
  output logic               q_pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [13:0] turntable_angle,
  output logic signed [13:0] shoulder_angle,
  output logic signed [13:0] elbow_angle,
  output logic               reachable,
  output logic               base_in_limits,
  output logic               shoulder_in_limits,
  output logic               elbow_in_limits,
  output logic               move_allowed
);
  import ikarm_pkg::*;

  localparam int SQ1_W      = 30;
  localparam int SQ1_LAT    = SQ1_W / 2;
  localparam int SQ2_W      = 60;
  localparam int SQ2_LAT    = SQ2_W / 2;
  localparam int CORDIC_LAT = CORDIC_ITERATIONS + 1;
  localparam int LAT        = 1 + SQ1_LAT + 6 + SQ2_LAT + CORDIC_LAT + 3;

  typedef struct packed {
    item_t              item;
    logic signed [16:0] r;
    logic signed [31:0] n1;
    logic signed [31:0] n2;
    logic               tri_ok;
  } side2_t;

  typedef struct packed {
    logic base_ok;
    logic both_neg;
    logic tri_ok;
  } side3_t;

  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !out_valid || !out_stall;
  assign q_pop     = adv && !q_empty;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], q_pop};
    end
  end

  // link squares follow the registers
  logic [25:0] l1sq;
  logic [25:0] l2sq;
  logic [51:0] l12;
  logic [53:0] q2c;

  assign l12 = l1sq * l2sq;

  always_ff @(posedge clk) begin
    l1sq <= cfg.upper_link_length * cfg.upper_link_length;
    l2sq <= cfg.fore_link_length * cfg.fore_link_length;
    q2c  <= {l12, 2'b00};
  end

  // s0: horizontal reach squared
  logic signed [27:0] xsq;
  logic signed [27:0] ysq;
  item_t              s0_item;
  logic [27:0]        s0_sxy;

  assign xsq = q_head.x * q_head.x;
  assign ysq = q_head.y * q_head.y;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item <= q_head;
      s0_sxy  <= $unsigned(xsq) + $unsigned(ysq);
    end
  end

  logic [SQ1_W/2-1:0] root1;
  item_t              d1 [SQ1_LAT];

  ikarm_isqrt #(.W(SQ1_W)) u_sqrt_reach (
    .clk      (clk),
    .en       (adv),
    .radicand ({s0_sxy, 2'b00}),
    .root     (root1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= s0_item;
      for (int k = 1; k < SQ1_LAT; k++) begin
        d1[k] <= d1[k-1];
      end
    end
  end

  // s2..s7: reach, d^2, cosine terms, triangle test
  logic [14:0]        rs1;
  item_t              s2_item, s3_item, s4_item, s5_item, s6_item, s7_item;
  logic signed [16:0] s2_r, s3_r, s4_r, s5_r, s6_r, s7_r;
  logic signed [33:0] rr_full;
  logic signed [33:0] hh_full;
  logic [29:0]        s3_rr, s3_hh;
  logic [29:0]        s4_d2;
  logic [55:0]        l1d2;
  logic signed [31:0] s5_n1, s5_n2, s6_n1, s6_n2, s7_n1, s7_n2;
  logic [57:0]        s5_q1, s6_q1;
  logic               s5_dpos, s6_dpos;
  logic signed [63:0] n1sq_full;
  logic signed [63:0] n2sq_full;
  logic [62:0]        s6_n1sq, s6_n2sq;
  logic signed [63:0] diff1;
  logic signed [63:0] diff2;
  logic [SQ2_W-1:0]   s7_sq1, s7_sq2;
  logic               s7_tri;

  assign rs1       = 15'((16'(root1) + 16'd1) >> 1);
  assign rr_full   = s2_r * s2_r;
  assign hh_full   = s2_item.hx * s2_item.hx;
  assign l1d2      = l1sq * s4_d2;
  assign n1sq_full = s5_n1 * s5_n1;
  assign n2sq_full = s5_n2 * s5_n2;
  assign diff1     = $signed({6'b0, s6_q1}) - $signed({1'b0, s6_n1sq});
  assign diff2     = $signed({10'b0, q2c}) - $signed({1'b0, s6_n2sq});

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= d1[SQ1_LAT-1];
      s2_r    <= $signed({2'b00, rs1}) - $signed({4'b0000, cfg.radial_offset});

      s3_item <= s2_item;
      s3_r    <= s2_r;
      s3_rr   <= rr_full[29:0];
      s3_hh   <= hh_full[29:0];

      s4_item <= s3_item;
      s4_r    <= s3_r;
      s4_d2   <= s3_rr + s3_hh;

      s5_item <= s4_item;
      s5_r    <= s4_r;
      s5_n1   <= $signed({6'b0, l1sq}) + $signed({2'b0, s4_d2}) - $signed({6'b0, l2sq});
      s5_n2   <= $signed({6'b0, l1sq}) + $signed({6'b0, l2sq}) - $signed({2'b0, s4_d2});
      s5_q1   <= {l1d2, 2'b00};
      s5_dpos <= (s4_d2 != '0);

      s6_item <= s5_item;
      s6_r    <= s5_r;
      s6_n1   <= s5_n1;
      s6_n2   <= s5_n2;
      s6_q1   <= s5_q1;
      s6_dpos <= s5_dpos;
      s6_n1sq <= n1sq_full[62:0];
      s6_n2sq <= n2sq_full[62:0];

      s7_item <= s6_item;
      s7_r    <= s6_r;
      s7_n1   <= s6_n1;
      s7_n2   <= s6_n2;
      s7_sq1  <= diff1[63] ? '0 : {diff1[57:0], 2'b00};
      s7_sq2  <= diff2[63] ? '0 : {diff2[57:0], 2'b00};
      s7_tri  <= !diff1[63] && !diff2[63] && s6_dpos &&
                 (cfg.upper_link_length != '0) && (cfg.fore_link_length != '0);
    end
  end

  logic [SQ2_W/2-1:0] root_a1;
  logic [SQ2_W/2-1:0] root_fa;
  side2_t             d2 [SQ2_LAT];

  ikarm_isqrt #(.W(SQ2_W)) u_sqrt_a1 (
    .clk      (clk),
    .en       (adv),
    .radicand (s7_sq1),
    .root     (root_a1)
  );

  ikarm_isqrt #(.W(SQ2_W)) u_sqrt_fa (
    .clk      (clk),
    .en       (adv),
    .radicand (s7_sq2),
    .root     (root_fa)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      d2[0] <= '{item: s7_item, r: s7_r, n1: s7_n1, n2: s7_n2, tri_ok: s7_tri};
      for (int k = 1; k < SQ2_LAT; k++) begin
        d2[k] <= d2[k-1];
      end
    end
  end

  // four angles in parallel
  side2_t                    d2o;
  logic [SQ2_W/2-1:0]        a1y;
  logic [SQ2_W/2-1:0]        fay;
  logic signed [ANGLE_W-1:0] z_a1, z_fa, z_a2, z_b;

  assign d2o = d2[SQ2_LAT-1];
  assign a1y = (SQ2_W/2)'(((SQ2_W/2+1)'(root_a1) + (SQ2_W/2+1)'(1)) >> 1);
  assign fay = (SQ2_W/2)'(((SQ2_W/2+1)'(root_fa) + (SQ2_W/2+1)'(1)) >> 1);

  ikarm_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_a1 (
    .clk   (clk),
    .en    (adv),
    .y_in  ($signed({2'b00, a1y})),
    .x_in  (d2o.n1),
    .z_out (z_a1)
  );

  ikarm_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_fa (
    .clk   (clk),
    .en    (adv),
    .y_in  ($signed({2'b00, fay})),
    .x_in  (d2o.n2),
    .z_out (z_fa)
  );

  ikarm_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_a2 (
    .clk   (clk),
    .en    (adv),
    .y_in  (CORDIC_IN_W'(d2o.r)),
    .x_in  (CORDIC_IN_W'(d2o.item.hx)),
    .z_out (z_a2)
  );

  ikarm_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic_base (
    .clk   (clk),
    .en    (adv),
    .y_in  (CORDIC_IN_W'(d2o.item.y)),
    .x_in  (CORDIC_IN_W'(d2o.item.x)),
    .z_out (z_b)
  );

  side3_t d3 [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      d3[0] <= '{base_ok: d2o.item.base_ok, both_neg: d2o.item.both_neg,
                 tri_ok: d2o.tri_ok};
      for (int k = 1; k < CORDIC_LAT; k++) begin
        d3[k] <= d3[k-1];
      end
    end
  end

  // s9..s11: servo mapping, rounding, limits
  side3_t                    s9_side, s10_side;
  logic signed [ANGLE_W-1:0] s9_bq, s9_big, s9_fa;
  logic signed [ANGLE_W-1:0] so_q, eo_q;
  logic signed [ROUND_W-1:0] s10_bo, s10_so, s10_eo;
  logic                      bl, sl, el;

  assign so_q = off_q(cfg.shoulder_servo_offset) + deg_q(180) - s9_big;
  assign eo_q = off_q(cfg.elbow_servo_offset) + s9_big + s9_fa - deg_q(180);

  assign bl = s10_side.base_ok && (s10_bo > lim(BASE_LO_DEG)) &&
              (s10_bo < lim(BASE_HI_DEG));
  assign sl = s10_side.tri_ok && (s10_so > lim(SHOULDER_LO_DEG)) &&
              (s10_so < lim(SHOULDER_HI_DEG));
  assign el = s10_side.tri_ok && (s10_eo > lim(ELBOW_LO_DEG)) &&
              (s10_eo < lim(ELBOW_HI_DEG));

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_side <= d3[CORDIC_LAT-1];
      s9_bq   <= z_b + (d3[CORDIC_LAT-1].both_neg ? deg_q(360) : '0) +
                 off_q(cfg.base_servo_offset);
      s9_big  <= z_a1 + z_a2;
      s9_fa   <= z_fa;

      s10_side <= s9_side;
      s10_bo   <= round_out(s9_bq);
      s10_so   <= round_out(so_q);
      s10_eo   <= round_out(eo_q);

      turntable_angle    <= s10_side.base_ok ? sat_out(s10_bo) : '0;
      shoulder_angle     <= s10_side.tri_ok ? sat_out(s10_so) : '0;
      elbow_angle        <= s10_side.tri_ok ? sat_out(s10_eo) : '0;
      reachable          <= s10_side.base_ok && s10_side.tri_ok;
      base_in_limits     <= bl;
      shoulder_in_limits <= sl;
      elbow_in_limits    <= el;
      move_allowed       <= s10_side.base_ok && s10_side.tri_ok && bl && sl && el;
    end
  end

endmodule

FILE: sv/three_joint_arm_inverse_kinematics_top.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics_top
// Turntable plus two-link arm inverse kinematics, one target per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with target_x/y/z (1/16 mm). A beat is
//   taken when in_valid is high and in_stall low.
//   Output channel: out_valid/out_stall with the three servo angles
//   (1/16 degree, saturated) and the reachable, limit and move_allowed flags.
//   Configuration: cfg_wr_en/cfg_index/cfg_data write one register per edge;
//   write only while no beat is in flight.
//   Throughput: one beat per cycle, sustained while out_stall stays low.
//   Path: between input and output beat lie the 15-stage reach square root,
//   the 30-stage triangle square roots and the CORDIC pipeline.
//   Structure: a front register classifies the target, a four-entry queue
//   decouples it from the solver pipeline, which advances as one unit and
//   ends in the output register.
//   Reset: clears the front, the queue and all pipeline valid bits and loads
//   the register defaults.
//   Receiver stall: the solver pipeline holds, the queue fills, then
//   in_stall rises; no beat is dropped.
// ----------------------------------------------------------------------------
module three_joint_arm_inverse_kinematics_top #(
  parameter int CORDIC_ITERATIONS = ikarm_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [13:0] target_x,
  input  logic signed [13:0] target_y,
  input  logic signed [13:0] target_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [13:0] turntable_angle,
  output logic signed [13:0] shoulder_angle,
  output logic signed [13:0] elbow_angle,
  output logic               reachable,
  output logic               base_in_limits,
  output logic               shoulder_in_limits,
  output logic               elbow_in_limits,
  output logic               move_allowed
);
  import ikarm_pkg::*;

  cfg_t  cfg;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  item_t q_item;
  item_t q_head;

  // Configuration registers; load defaults on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.z_bracket_offset      <= 13'sd480;
      cfg.radial_offset         <= 13'd1520;
      cfg.shoulder_height       <= 13'd2304;
      cfg.upper_link_length     <= 13'd1920;
      cfg.fore_link_length      <= 13'd1920;
      cfg.shoulder_servo_offset <= 13'd1648;
      cfg.elbow_servo_offset    <= 13'd1040;
      cfg.base_servo_offset     <= 13'd760;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_Z_BRACKET_OFFSET:      cfg.z_bracket_offset      <= $signed(cfg_data);
        REG_RADIAL_OFFSET:         cfg.radial_offset         <= cfg_data;
        REG_SHOULDER_HEIGHT:       cfg.shoulder_height       <= cfg_data;
        REG_UPPER_LINK_LENGTH:     cfg.upper_link_length     <= cfg_data;
        REG_FORE_LINK_LENGTH:      cfg.fore_link_length      <= cfg_data;
        REG_SHOULDER_SERVO_OFFSET: cfg.shoulder_servo_offset <= cfg_data;
        REG_ELBOW_SERVO_OFFSET:    cfg.elbow_servo_offset    <= cfg_data;
        REG_BASE_SERVO_OFFSET:     cfg.base_servo_offset     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: take the target beat and classify it.
  ikarm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .target_x (target_x),
    .target_y (target_y),
    .target_z (target_z),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // Queue: let front and solver stall on their own.
  ikarm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // Back: solve and drive the output beat.
  ikarm_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .turntable_angle    (turntable_angle),
    .shoulder_angle     (shoulder_angle),
    .elbow_angle        (elbow_angle),
    .reachable          (reachable),
    .base_in_limits     (base_in_limits),
    .shoulder_in_limits (shoulder_in_limits),
    .elbow_in_limits    (elbow_in_limits),
    .move_allowed       (move_allowed)
  );

endmodule

FILE: verif/three_joint_arm_inverse_kinematics_top_tb.sv
// ----------------------------------------------------------------------------
// three_joint_arm_inverse_kinematics_top_tb
// Drives target points through the arm solver under random idling and a long
// receiver hold-off, predicts every servo angle and flag in fixed point, and
// checks each output beat in order across several register settings.
// ----------------------------------------------------------------------------
module three_joint_arm_inverse_kinematics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ikarm_pkg::*;

  // Expected solution for one target.
  typedef struct {
    logic signed [13:0] base;
    logic signed [13:0] shoulder;
    logic signed [13:0] elbow;
    logic reach, base_lim, shoulder_lim, elbow_lim, move;
  } arm_pose_t;

  // Q20 arctangent table, 2^-i.
  localparam longint ATAN_TBL [16] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833};

  // Register shadow, as raw 13-bit values.
  logic [12:0] cfg_shadow [8];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_nearest(longint s);
    longint n, res, b;
    n = s * 4;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return (res + 1) >>> 1;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q20 degrees.
  function automatic longint vector_angle(longint y, longint x);
    longint z, t;
    z = 0;
    x = x <<< QF;
    y = y <<< QF;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 64'sd90 <<< QF;
      end else begin
        t = x; x = -y; y = t; z = -(64'sd90 <<< QF);
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        t = x + fshr(y, i); y = y - fshr(x, i); z += ATAN_TBL[i];
      end else begin
        t = x - fshr(y, i); y = y + fshr(x, i); z -= ATAN_TBL[i];
      end
      x = t;
    end
    return z;
  endfunction

  function automatic longint q_to_units(longint q);
    return fshr(q + (64'sd1 <<< (OUT_SHIFT - 1)), OUT_SHIFT);
  endfunction

  function automatic logic signed [13:0] clamp14(longint v);
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[13:0];
  endfunction

  function automatic arm_pose_t solve_pose(logic signed [13:0] tx, logic signed [13:0] ty,
                                           logic signed [13:0] tz);
    arm_pose_t p;
    longint x, y, zz, r, hx, d2, l1, l2, b, bo, so, eo, n1, q1, n2, q2, a1, fa, big;
    logic base_ok, tri_ok;
    x = tx; y = ty;
    zz = longint'(tz) + longint'($signed(cfg_shadow[REG_Z_BRACKET_OFFSET]));
    r = root_nearest(x * x + y * y) - longint'(cfg_shadow[REG_RADIAL_OFFSET]);
    hx = longint'(cfg_shadow[REG_SHOULDER_HEIGHT]) - zz;
    d2 = r * r + hx * hx;
    l1 = cfg_shadow[REG_UPPER_LINK_LENGTH];
    l2 = cfg_shadow[REG_FORE_LINK_LENGTH];
    base_ok = (x != 0) || (y != 0);
    tri_ok = 0;
    bo = 0; so = 0; eo = 0;
    p.base_lim = 0; p.shoulder_lim = 0; p.elbow_lim = 0;
    if (base_ok) begin
      b = vector_angle(y, x);
      if (x < 0 && y < 0) b += 64'sd360 <<< QF;
      bo = q_to_units(b + (longint'(cfg_shadow[REG_BASE_SERVO_OFFSET]) <<< OUT_SHIFT));
      p.base_lim = bo > 0 && bo < 270 * 16;
    end
    if (l1 > 0 && l2 > 0 && d2 > 0) begin
      n1 = l1 * l1 + d2 - l2 * l2;
      q1 = 4 * l1 * l1 * d2;
      n2 = l1 * l1 + l2 * l2 - d2;
      q2 = 4 * l1 * l1 * l2 * l2;
      if (n1 * n1 <= q1 && n2 * n2 <= q2) begin
        a1 = vector_angle(root_nearest(q1 - n1 * n1), n1);
        fa = vector_angle(root_nearest(q2 - n2 * n2), n2);
        big = a1 + vector_angle(r, hx);
        tri_ok = 1;
        so = q_to_units((longint'(cfg_shadow[REG_SHOULDER_SERVO_OFFSET]) <<< OUT_SHIFT)
                        + (64'sd180 <<< QF) - big);
        eo = q_to_units((longint'(cfg_shadow[REG_ELBOW_SERVO_OFFSET]) <<< OUT_SHIFT)
                        + big + fa - (64'sd180 <<< QF));
        p.shoulder_lim = so > 75 * 16 && so < 170 * 16;
        p.elbow_lim = eo > 50 * 16 && eo < 160 * 16;
      end
    end
    p.base = clamp14(bo);
    p.shoulder = clamp14(so);
    p.elbow = clamp14(eo);
    p.reach = base_ok && tri_ok;
    p.move = p.reach && p.base_lim && p.shoulder_lim && p.elbow_lim;
    return p;
  endfunction

  class pose_scoreboard;
    arm_pose_t pending[$];
    int errors;
    int solved;

    function void note_target(arm_pose_t p);
      pending.push_back(p);
    endfunction

    function void check_pose(arm_pose_t got);
      arm_pose_t exp_p;
      if (pending.size() == 0) begin
        $error("output beat with nothing pending");
        errors++;
        return;
      end
      exp_p = pending.pop_front();
      solved++;
      if (got.base !== exp_p.base) begin
        $error("turntable_angle exp %0d got %0d", exp_p.base, got.base); errors++;
      end
      if (got.shoulder !== exp_p.shoulder) begin
        $error("shoulder_angle exp %0d got %0d", exp_p.shoulder, got.shoulder); errors++;
      end
      if (got.elbow !== exp_p.elbow) begin
        $error("elbow_angle exp %0d got %0d", exp_p.elbow, got.elbow); errors++;
      end
      if (got.reach !== exp_p.reach) begin
        $error("reachable exp %0b got %0b", exp_p.reach, got.reach); errors++;
      end
      if (got.base_lim !== exp_p.base_lim) begin
        $error("base_in_limits exp %0b got %0b", exp_p.base_lim, got.base_lim); errors++;
      end
      if (got.shoulder_lim !== exp_p.shoulder_lim) begin
        $error("shoulder_in_limits exp %0b got %0b", exp_p.shoulder_lim,
               got.shoulder_lim); errors++;
      end
      if (got.elbow_lim !== exp_p.elbow_lim) begin
        $error("elbow_in_limits exp %0b got %0b", exp_p.elbow_lim, got.elbow_lim); errors++;
      end
      if (got.move !== exp_p.move) begin
        $error("move_allowed exp %0b got %0b", exp_p.move, got.move); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [13:0] target_x = '0, target_y = '0, target_z = '0;
  logic out_valid;
  logic out_stall = 1;
  logic signed [13:0] turntable_angle, shoulder_angle, elbow_angle;
  logic reachable, base_in_limits, shoulder_in_limits, elbow_in_limits, move_allowed;

  pose_scoreboard sb = new();
  int sent;
  int idle_pct = 14;     // idling percentage for both sides
  bit hold_off = 0;      // receiver long hold-off request
  bit hold_done = 0;
  int quiet_cycles = 0;

  three_joint_arm_inverse_kinematics_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= 300) hold_done = 1;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
      @(posedge clk);
    end
  end

  // Check every output beat; count cycles with no accepted beat.
  always @(posedge clk) begin
    arm_pose_t got;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        got.base = turntable_angle; got.shoulder = shoulder_angle; got.elbow = elbow_angle;
        got.reach = reachable; got.base_lim = base_in_limits;
        got.shoulder_lim = shoulder_in_limits; got.elbow_lim = elbow_in_limits;
        got.move = move_allowed;
        sb.check_pose(got);
      end
    end
  end

  // Watchdog.
  initial begin
    forever begin
      @(posedge clk);
      if (quiet_cycles > 5000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one beat; hold it until taken, then note the expected pose.
  task automatic send_target(logic signed [13:0] x, logic signed [13:0] y,
                             logic signed [13:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    target_x <= x; target_y <= y; target_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_target(solve_pose(x, y, z));
    sent++;
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Drive one write for a cycle; the caller drops the enable after the last.
  task automatic write_reg(reg_index_t idx, logic [12:0] val);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    cfg_shadow[idx] = val;
    @(posedge clk);
  endtask

  // Random target, mostly within +/-4000 in x and y and +/-3000 in z.
  task automatic send_random();
    logic signed [13:0] x, y, z;
    if ($urandom_range(3) == 0) begin
      x = 14'($urandom); y = 14'($urandom); z = 14'($urandom);
    end else begin
      x = $signed(14'($urandom_range(8000))) - 14'sd4000;
      y = $signed(14'($urandom_range(8000))) - 14'sd4000;
      z = $signed(14'($urandom_range(6000))) - 14'sd3000;
      if ($urandom_range(19) == 0) begin
        x = 0; y = 0;
      end
    end
    send_target(x, y, z);
  endtask

  task automatic set_arm(logic [12:0] zb, logic [12:0] ro, logic [12:0] sh, logic [12:0] l1,
                         logic [12:0] l2, logic [12:0] so, logic [12:0] eo, logic [12:0] bo);
    write_reg(REG_Z_BRACKET_OFFSET, zb);
    write_reg(REG_RADIAL_OFFSET, ro);
    write_reg(REG_SHOULDER_HEIGHT, sh);
    write_reg(REG_UPPER_LINK_LENGTH, l1);
    write_reg(REG_FORE_LINK_LENGTH, l2);
    write_reg(REG_SHOULDER_SERVO_OFFSET, so);
    write_reg(REG_ELBOW_SERVO_OFFSET, eo);
    write_reg(REG_BASE_SERVO_OFFSET, bo);
    cfg_wr_en <= 0;
  endtask

  initial begin
    cfg_shadow = '{480, 1520, 2304, 1920, 1920, 1648, 1040, 760};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: axis, extremes, shoulder height, quadrants, reach limits.
    send_target(0, 0, 0);
    send_target(0, 0, 14'sd8191);
    send_target(14'sd8191, 14'sd8191, 14'sd8191);
    send_target(-14'sd8192, -14'sd8192, -14'sd8192);
    send_target(-14'sd8192, 14'sd8191, 0);
    send_target(14'sd8191, -14'sd8192, 0);
    send_target(14'sd3000, 0, 14'sd1824);       // target at shoulder height
    send_target(14'sd1000, 0, 14'sd1824);       // negative reach, level
    send_target(14'sd500, 14'sd200, 14'sd4000); // negative reach, above shoulder
    send_target(-14'sd3000, 14'sd1, 14'sd500);
    send_target(-14'sd3000, -14'sd1, 14'sd500);
    send_target(0, 14'sd3000, 0);
    send_target(0, -14'sd3000, 0);
    send_target(14'sd3000, 14'sd2000, -14'sd500);
    send_target(14'sd5360, 0, 14'sd1824);       // fully stretched
    send_target(14'sd1520, 0, 14'sd1824);       // d = 0
    send_target(-14'sd1, 0, 0);
    send_target(0, 0, -14'sd8192);

    // Default arm, random with idling on both sides.
    for (int i = 0; i < 300; i++) send_random();

    // Long receiver hold-off while beats keep coming, no idling.
    idle_pct = 0;
    hold_off = 1;
    for (int i = 0; i < 150; i++) send_random();
    idle_pct = 14;
    go_idle();

    // Extremes of every register.
    set_arm(13'h0FFF, 0, 0, 1, 1, 0, 0, 0);
    for (int i = 0; i < 150; i++) send_random();
    go_idle();
    set_arm(13'h1000, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
    for (int i = 0; i < 150; i++) send_random();
    go_idle();
    set_arm(0, 500, 1000, 0, 2500, 5759, 5759, 5759);
    for (int i = 0; i < 100; i++) send_random();
    go_idle();

    // Random arms, with a stretch of no idling.
    for (int ph = 0; ph < 4; ph++) begin
      set_arm(13'($urandom), 13'($urandom_range(3000)), 13'($urandom_range(4000)),
              13'($urandom_range(1, 4000)), 13'($urandom_range(1, 4000)),
              13'($urandom_range(5759)), 13'($urandom_range(5759)),
              13'($urandom_range(5759)));
      idle_pct = (ph == 1) ? 0 : 14;
      for (int i = 0; i < 125; i++) send_random();
      go_idle();
    end

    $display("Covered %0d targets, %0d solutions checked, over 8 arm settings",
             sent, sb.solved);
    $display("including a long output hold-off and degenerate register values");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/ikarm_pkg.sv
sv/ikarm_front.sv
sv/ikarm_fifo.sv
sv/ikarm_isqrt.sv
sv/ikarm_cordic.sv
sv/ikarm_back.sv
sv/three_joint_arm_inverse_kinematics_top.sv
verif/three_joint_arm_inverse_kinematics_top_tb.sv
